@@ sv/mdc_pkg.sv @@
// Package: shared types, state codes and command codes of the dispense controller.
package mdc_pkg;
    localparam int MAX_DIGITS = 15;
    localparam int MASS_BITS  = 17;
    localparam int VAL_BITS   = 50;
    localparam int GOAL_BITS  = 32;
    localparam int PRICE_BITS = 20;
    localparam int SETTLE_BITS = 10;
    localparam int PROD_BITS  = 60;   // amount*1000 < 2^60
    localparam int DIV_STEPS  = PROD_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ENTRY  = 3'd1;
    localparam logic [2:0] ST_READY  = 3'd2;
    localparam logic [2:0] ST_DISP   = 3'd3;
    localparam logic [2:0] ST_PAUSED = 3'd4;
    localparam logic [2:0] ST_STOP   = 3'd5;
    localparam logic [2:0] ST_CALIB  = 3'd6;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_RSTS  = 3'd3;
    localparam logic [2:0] CMD_RSTL  = 3'd4;
    localparam logic [2:0] CMD_MODE  = 3'd5;
    localparam logic [2:0] CMD_KEY   = 3'd6;

    localparam logic [3:0] KEY_ENTER = 4'd10;
    localparam logic [3:0] KEY_CLEAR = 4'd11;
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;

    localparam logic [0:0] REG_PRICE  = 1'd0;
    localparam logic [0:0] REG_SETTLE = 1'd1;

    // Controller to datapath commands.
    typedef struct packed {
        logic step;       // apply one event
        logic div_start;  // load divider
        logic div_step;   // one restoring step
        logic div_done;   // commit quotient, go to ready
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic needs_div;  // enter key in entry mode with nonzero amount and price
    } t_dp_sts;
endpackage

@@ sv/mass_dispense_controller.sv @@
// Top level: dispense controller with APB register file, controller and datapath.
// An event item yields its result in the cycle after acceptance; an enter key
// with a nonzero amount and price goes through the 60-step restoring divider first.
// One item at a time: the next item is accepted once the result leaves.
// Reset (i_rst_n low, synchronous): state idle, all registers but the divider's zero,
// price_per_kg 0, settle_ticks 10, output empty.
module mass_dispense_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [3:0]  i_key_code,
    input  logic [16:0] i_mass_g,
    input  logic        i_reading_fresh,
    input  logic        i_safety_alarm,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_state_code,
    output logic        o_relay_closed,
    output logic        o_monitoring_on,
    output logic [16:0] o_dispensed_g,
    output logic [49:0] o_entry_value,
    output logic [3:0]  o_digit_count,
    output logic [49:0] o_paid_amount,
    output logic [31:0] o_target_g,
    output logic        o_safety_latched,
    output logic        o_calib_key_valid,
    output logic [3:0]  o_calib_key
);
    import mdc_pkg::*;

    logic [19:0] r_price;
    logic [9:0]  r_settle_ticks;
    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic        wr;

    // Registers: word 0 price per kg, word 1 settle ticks.
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_price        <= '0;
            r_settle_ticks <= 10'd10;
        end else if (wr && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_PRICE)  r_price        <= pwdata[19:0];
            if (paddr[2] == REG_SETTLE) r_settle_ticks <= pwdata[9:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_PRICE) prdata = {12'b0, r_price};
            else prdata = {22'b0, r_settle_ticks};
        end
    end

    mdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mdc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_price           (r_price),
        .i_settle          (r_settle_ticks),
        .i_command         (i_command),
        .i_key_code        (i_key_code),
        .i_mass_g          (i_mass_g),
        .i_reading_fresh   (i_reading_fresh),
        .i_safety_alarm    (i_safety_alarm),
        .o_state_code      (o_state_code),
        .o_relay_closed    (o_relay_closed),
        .o_monitoring_on   (o_monitoring_on),
        .o_dispensed_g     (o_dispensed_g),
        .o_entry_value     (o_entry_value),
        .o_digit_count     (o_digit_count),
        .o_paid_amount     (o_paid_amount),
        .o_target_g        (o_target_g),
        .o_safety_latched  (o_safety_latched),
        .o_calib_key_valid (o_calib_key_valid),
        .o_calib_key       (o_calib_key)
    );
endmodule

@@ sv/mdc_ctrl.sv @@
// Controller: sequences event application and the iterative divide.
module mdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    input  mdc_pkg::t_dp_sts i_sts,
    output mdc_pkg::t_dp_cmd o_cmd
);
    import mdc_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_DIV  = 2'd1;
    localparam logic [1:0] C_OUT  = 2'd2;
    localparam logic [1:0] C_DONE = 2'd3;

    logic [1:0] r_st, n_st;
    logic [5:0] r_cnt, n_cnt;
    logic       acc;

    assign o_in_stall  = (r_st != C_IDLE);
    assign o_out_valid = (r_st == C_OUT);
    assign acc = i_in_valid && (r_st == C_IDLE);

    always_comb begin
        n_st  = r_st;
        n_cnt = r_cnt;
        o_cmd = '0;
        unique case (r_st)
            C_IDLE: begin
                if (acc) begin
                    if (i_sts.needs_div) begin
                        o_cmd.div_start = 1'b1;
                        n_cnt = '0;
                        n_st  = C_DIV;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_st = C_OUT;
                    end
                end
            end
            C_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    n_st = C_DONE;
                end
            end
            C_OUT: begin
                if (!i_out_stall) n_st = C_IDLE;
            end
            C_DONE: begin
                // divide finished: commit
                o_cmd.div_done = 1'b1;
                n_st = C_OUT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= C_IDLE;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
        end
    end
endmodule

@@ sv/mdc_dp.sv @@
// Datapath: controller state registers, entry buffer, divider and result.
module mdc_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mdc_pkg::t_dp_cmd      i_cmd,
    output mdc_pkg::t_dp_sts      o_sts,
    input  logic [19:0]           i_price,
    input  logic [9:0]            i_settle,
    input  logic [2:0]            i_command,
    input  logic [3:0]            i_key_code,
    input  logic [16:0]           i_mass_g,
    input  logic                  i_reading_fresh,
    input  logic                  i_safety_alarm,
    output logic [2:0]            o_state_code,
    output logic                  o_relay_closed,
    output logic                  o_monitoring_on,
    output logic [16:0]           o_dispensed_g,
    output logic [49:0]           o_entry_value,
    output logic [3:0]            o_digit_count,
    output logic [49:0]           o_paid_amount,
    output logic [31:0]           o_target_g,
    output logic                  o_safety_latched,
    output logic                  o_calib_key_valid,
    output logic [3:0]            o_calib_key
);
    import mdc_pkg::*;

    logic [2:0]  r_mode, n_mode, r_prior, n_prior;
    logic [49:0] r_typed, n_typed, r_acc, n_acc;
    logic [3:0]  r_digits, n_digits;
    logic [31:0] r_goal, n_goal;
    logic [16:0] r_start, n_start, r_carry, n_carry;
    logic        r_armed, n_armed, r_trip, n_trip;
    logic [9:0]  r_settle, n_settle;
    logic [16:0] r_disp, n_disp;
    logic        r_ckv, n_ckv;
    logic [3:0]  r_ck, n_ck;

    // divider
    logic [PROD_BITS-1:0] r_quo;
    logic [20:0]          r_rem;
    logic [20:0]          rem_sh, rem_sub;
    logic [PROD_BITS-1:0] prod;

    logic [16:0] cur_disp;

    function automatic logic [16:0] disp_of(input logic [16:0] st, input logic [16:0] ca,
                                            input logic [16:0] m);
        logic [18:0] d;
        d = {2'b0, st} + {2'b0, ca} - {2'b0, m};
        if (d[18]) disp_of = '0;
        else if (d[17]) disp_of = '1;
        else disp_of = d[16:0];
    endfunction

    assign cur_disp = disp_of(r_start, r_carry, i_mass_g);

    assign o_sts.needs_div = (i_command == CMD_KEY) && (r_mode == ST_ENTRY) &&
                             (i_key_code == KEY_ENTER) && (r_typed != '0) &&
                             (i_price != '0);

    // amount*1000 = amount*1024 - amount*16 - amount*8
    assign prod = ({r_typed, 10'b0}) - ({6'b0, r_typed, 4'b0}) - ({7'b0, r_typed, 3'b0});

    assign rem_sh  = {r_rem[19:0], r_quo[PROD_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, i_price};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= prod;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (!rem_sub[20]) begin
                r_rem <= rem_sub;
                r_quo <= {r_quo[PROD_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[PROD_BITS-2:0], 1'b0};
            end
        end
    end

    // Apply one event, following the nested state entry actions.
    always_comb begin
        logic [2:0] tgt;
        logic       go;
        logic       armed_t;
        logic [9:0] sl;
        n_mode = r_mode; n_prior = r_prior; n_typed = r_typed; n_digits = r_digits;
        n_acc = r_acc; n_goal = r_goal; n_start = r_start; n_carry = r_carry;
        n_armed = r_armed; n_trip = r_trip; n_settle = r_settle;
        n_ckv = 1'b0; n_ck = '0;
        tgt = r_mode; go = 1'b0;
        armed_t = r_armed; sl = r_settle;
        unique case (i_command)
            CMD_TICK: begin
                if (r_mode == ST_DISP) begin
                    if (!r_armed) begin
                        if (sl != '0) sl = sl - 10'd1;
                        if (sl == '0) armed_t = 1'b1;
                    end
                    n_settle = sl;
                    n_armed = armed_t;
                    if ((armed_t && i_safety_alarm) || r_trip) begin
                        go = 1'b1; tgt = ST_STOP;
                    end else if (!i_reading_fresh) begin
                        n_trip = 1'b1; go = 1'b1; tgt = ST_STOP;
                    end else if ({15'b0, cur_disp} >= r_goal) begin
                        go = 1'b1; tgt = ST_IDLE;
                    end
                end
            end
            CMD_START: begin
                if (r_mode == ST_IDLE) begin
                    go = 1'b1; tgt = ST_ENTRY;
                end else if (r_mode == ST_READY || r_mode == ST_PAUSED) begin
                    go = 1'b1; tgt = ST_DISP;
                end
            end
            CMD_STOP: begin
                if (r_mode == ST_DISP) begin go = 1'b1; tgt = ST_PAUSED; end
            end
            CMD_RSTS: begin
                if (r_mode != ST_CALIB) begin go = 1'b1; tgt = ST_IDLE; end
            end
            CMD_RSTL: begin go = 1'b1; tgt = ST_IDLE; end
            CMD_MODE: begin
                if (r_mode == ST_IDLE) begin go = 1'b1; tgt = ST_CALIB; end
                else if (r_mode == ST_CALIB) begin go = 1'b1; tgt = ST_IDLE; end
            end
            CMD_KEY: begin
                if (r_mode == ST_ENTRY) begin
                    if (i_key_code <= KEY_DIGIT_MAX) begin
                        if (r_digits < 4'(MAX_DIGITS)) begin
                            n_typed = {r_typed[46:0], 3'b0} + {r_typed[48:0], 1'b0}
                                      + {46'b0, i_key_code};
                            n_digits = r_digits + 4'd1;
                        end
                    end else if (i_key_code == KEY_ENTER) begin
                        // a nonzero amount with a nonzero price is handled by the divider path
                        n_acc = r_typed;
                        n_typed = '0; n_digits = '0;
                    end else if (i_key_code == KEY_CLEAR) begin
                        n_typed = '0; n_digits = '0;
                    end
                end else if (r_mode == ST_CALIB) begin
                    n_ckv = 1'b1; n_ck = i_key_code;
                end
            end
            default: ;
        endcase

        if (go && tgt != r_mode) begin
            n_prior = r_mode;
            n_mode  = tgt;
            unique case (tgt)
                ST_IDLE: begin n_armed = 1'b0; n_trip = 1'b0; end
                ST_ENTRY: begin
                    n_typed = '0; n_digits = '0; n_acc = '0; n_goal = '0;
                end
                ST_DISP: begin
                    if (!i_reading_fresh) begin
                        n_prior = ST_DISP; n_mode = ST_STOP; n_armed = 1'b0;
                    end else begin
                        if (r_mode != ST_PAUSED) n_carry = '0;
                        n_start = i_mass_g;
                        n_armed = 1'b0;
                        n_settle = i_settle;
                    end
                end
                ST_PAUSED: begin
                    if (r_mode == ST_DISP) begin
                        n_carry = cur_disp;
                        n_start = i_mass_g;
                    end
                    n_armed = 1'b0;
                end
                ST_STOP, ST_CALIB: n_armed = 1'b0;
                default: ;
            endcase
        end

        if (n_mode == ST_DISP || n_mode == ST_PAUSED)
            n_disp = disp_of(n_start, n_carry, i_mass_g);
        else
            n_disp = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ST_IDLE; r_prior <= ST_IDLE; r_typed <= '0; r_digits <= '0;
            r_acc <= '0; r_goal <= '0; r_start <= '0; r_carry <= '0;
            r_armed <= 1'b0; r_settle <= '0; r_trip <= 1'b0;
            r_disp <= '0; r_ckv <= 1'b0; r_ck <= '0;
        end else if (i_cmd.step) begin
            r_mode <= n_mode; r_prior <= n_prior; r_typed <= n_typed;
            r_digits <= n_digits; r_acc <= n_acc; r_goal <= n_goal;
            r_start <= n_start; r_carry <= n_carry; r_armed <= n_armed;
            r_settle <= n_settle; r_trip <= n_trip; r_disp <= n_disp;
            r_ckv <= n_ckv; r_ck <= n_ck;
        end else if (i_cmd.div_start) begin
            r_acc <= r_typed;
            r_ckv <= 1'b0; r_ck <= '0; r_disp <= '0;
        end else if (i_cmd.div_done) begin
            r_goal <= (r_quo[PROD_BITS-1:GOAL_BITS] != '0) ? '1 : r_quo[GOAL_BITS-1:0];
            r_prior <= r_mode;
            r_mode <= ST_READY;
        end
    end

    assign o_state_code      = r_mode;
    assign o_relay_closed    = (r_mode == ST_DISP);
    assign o_monitoring_on   = r_armed;
    assign o_dispensed_g     = r_disp;
    assign o_entry_value     = r_typed;
    assign o_digit_count     = r_digits;
    assign o_paid_amount     = r_acc;
    assign o_target_g        = r_goal;
    assign o_safety_latched  = r_trip;
    assign o_calib_key_valid = r_ckv;
    assign o_calib_key       = r_ck;
endmodule
